// ===== hw/rtl/lcdws_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdws_pkg: shared types and constants of the character LCD write sequencer
// Opcodes, bus modes, register indexes, the queue entry and the row offsets.
// ----------------------------------------------------------------------------
package lcdws_pkg;

   // Request opcodes as they arrive on the input channel.
   typedef enum logic [1:0] {
      OP_COMMAND = 2'd0,
      OP_DATA    = 2'd1,
      OP_CURSOR  = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   // Bus modes. The unused fourth code behaves as the eight-bit bus.
   localparam logic [1:0] MODE_8BIT  = 2'd0;
   localparam logic [1:0] MODE_UPPER = 2'd1;
   localparam logic [1:0] MODE_LOWER = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUS_MODE   = 1'b0,
      CSR_PHASE_HOLD = 1'b1
   } csr_index_type;

   localparam logic [1:0]  BUS_MODE_RESET   = MODE_UPPER;
   localparam logic [15:0] PHASE_HOLD_RESET = 16'd600;

   localparam logic [5:0] MAX_COLUMN   = 6'd39;
   localparam logic [7:0] SET_DDRAM    = 8'h80;

   // Phase numbering of one request.
   typedef logic [2:0] phase_type;
   localparam phase_type PHASE_LAST_NIBBLE = 3'd6;
   localparam phase_type PHASE_LAST_BYTE   = 3'd3;

   // Queue between the front and the back.
   localparam int QDEPTH = 2;

   typedef struct packed {
      logic       rs;
      logic [7:0] byte_val;
   } entry_type;

   typedef struct packed {
      logic      busy;
      phase_type phase;
   } back_status_type;

   // DDRAM address of the first column of each display row.
   function automatic logic [7:0] row_offset(input logic [1:0] row);
      logic [7:0] off;
      case (row)
         2'd0:    off = 8'h00;
         2'd1:    off = 8'h40;
         2'd2:    off = 8'h10;
         2'd3:    off = 8'h50;
         default: off = 8'h00;
      endcase
      return off;
   endfunction

endpackage

// ===== hw/rtl/lcdws_front.sv =====
// ----------------------------------------------------------------------------
// lcdws_front: request intake
// Accepts requests, turns cursor moves into a set-address command and pushes
// the resulting byte and register select into the queue.
// ----------------------------------------------------------------------------
module lcdws_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [7:0]           req_byte_value,
   input  logic [1:0]           req_row,
   input  logic [5:0]           req_column,
   input  logic                 q_full,
   output logic                 q_push,
   output lcdws_pkg::entry_type q_entry
);
   import lcdws_pkg::*;

   opcode_type op;
   logic [5:0] col_sat;
   logic [7:0] cursor_byte;

   always_comb begin
      op          = opcode_type'(req_opcode);
      col_sat     = (req_column > MAX_COLUMN) ? MAX_COLUMN : req_column;
      cursor_byte = ({2'b00, col_sat} + row_offset(req_row)) | SET_DDRAM;
      q_entry.rs       = 1'b0;
      q_entry.byte_val = req_byte_value;
      case (op)
         OP_DATA: begin
            q_entry.rs = 1'b1;
         end
         OP_CURSOR: begin
            q_entry.byte_val = cursor_byte;
         end
         default: begin
            q_entry.rs = 1'b0;
         end
      endcase
   end

   // The unused opcode is taken and dropped without touching the queue.
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full && (op != OP_NONE);

endmodule

// ===== hw/rtl/lcdws_queue.sv =====
// ----------------------------------------------------------------------------
// lcdws_queue: short request queue
// A small first-in first-out buffer that decouples intake from the phase
// sequencer.
// ----------------------------------------------------------------------------
module lcdws_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lcdws_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output lcdws_pkg::entry_type head_entry
);
   import lcdws_pkg::*;

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);

   entry_type        mem [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      full       = (count_ff == CNT_W'(QDEPTH));
      head_valid = (count_ff != '0);
      head_entry = mem[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/lcdws_back.sv =====
// ----------------------------------------------------------------------------
// lcdws_back: pin phase sequencer
// Expands each queued byte into its pin phases, one per cycle unless rsp_ready
// stalls, into an output register, and keeps the latched data port value.
// ----------------------------------------------------------------------------
module lcdws_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 bus_mode,
   input  logic [15:0]                phase_hold,
   input  logic                       q_valid,
   input  lcdws_pkg::entry_type       q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_rs_pin,
   output logic                       rsp_rw_pin,
   output logic                       rsp_enable_pin,
   output logic [7:0]                 rsp_data_port,
   output logic [15:0]                rsp_hold_time,
   output logic                       rsp_last_phase,
   output lcdws_pkg::back_status_type status
);
   import lcdws_pkg::*;

   logic        busy_ff, busy_in;
   phase_type   phase_ff, phase_in;
   entry_type   cur_ff, cur_in;
   logic [7:0]  latch_ff, latch_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rs_ff, en_ff, last_ff;
   logic [7:0]  port_ff;
   logic [15:0] hold_ff;

   entry_type   act;
   logic        act_valid;
   phase_type   phase;
   logic        nibble_mode, upper;
   phase_type   last_idx;
   logic [7:0]  hi_port, lo_port, port;
   logic        en, is_last, advance;
   logic [15:0] hold;

   always_comb begin
      act_valid   = busy_ff || q_valid;
      act         = busy_ff ? cur_ff : q_head;
      phase       = busy_ff ? phase_ff : '0;
      nibble_mode = (bus_mode == MODE_UPPER) || (bus_mode == MODE_LOWER);
      upper       = (bus_mode == MODE_UPPER);
      last_idx    = nibble_mode ? PHASE_LAST_NIBBLE : PHASE_LAST_BYTE;
      hold        = (phase_hold == '0) ? 16'd1 : phase_hold;
      hi_port = upper ? {act.byte_val[7:4], latch_ff[3:0]}
                      : {latch_ff[7:4], act.byte_val[7:4]};
      lo_port = upper ? {act.byte_val[3:0], latch_ff[3:0]}
                      : {latch_ff[7:4], act.byte_val[3:0]};
      case (phase)
         3'd0: begin en = 1'b0; port = latch_ff; end
         3'd1: begin en = 1'b1; port = latch_ff; end
         3'd2: begin en = 1'b1; port = nibble_mode ? hi_port : act.byte_val; end
         3'd3: begin en = 1'b0; port = nibble_mode ? hi_port : act.byte_val; end
         3'd4: begin en = 1'b1; port = hi_port; end
         3'd5: begin en = 1'b1; port = lo_port; end
         3'd6: begin en = 1'b0; port = lo_port; end
         default: begin en = 1'b0; port = latch_ff; end
      endcase
      is_last = (phase == last_idx);
      advance = act_valid && (!rsp_valid_ff || rsp_ready);
      q_pop   = advance && !busy_ff;

      busy_in  = advance ? !is_last : busy_ff;
      phase_in = advance ? phase + phase_type'(1) : phase_ff;
      cur_in   = q_pop ? q_head : cur_ff;
      latch_in = (advance && is_last) ? port : latch_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         rs_ff   <= act.rs;
         en_ff   <= en;
         port_ff <= port;
         hold_ff <= hold;
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= '0;
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rs_pin     = rs_ff;
   assign rsp_rw_pin     = 1'b0;
   assign rsp_enable_pin = en_ff;
   assign rsp_data_port  = port_ff;
   assign rsp_hold_time  = hold_ff;
   assign rsp_last_phase = last_ff;
   assign status.busy    = busy_ff;
   assign status.phase   = phase_ff;

endmodule

// ===== hw/rtl/char_lcd_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer: character LCD write sequencer
// Turns command, data and cursor requests into timed RS/RW/E/data pin phases.
// ----------------------------------------------------------------------------
// Each accepted item is a command byte, a data byte or a cursor move; a cursor
// move becomes the set-address command 0x80 or'ed with the saturated column
// plus the row offset. The block answers every item with a run of pin phase
// items on the rsp_ channel, one per clock cycle while rsp_ready does not stall
// them: seven phases in the two four-bit bus modes and four in the eight-bit
// mode. The phase sequencer inserts no idle phase between the last phase of
// one item and the first phase of the next. An item with the unused opcode is
// taken and produces nothing. Intake and sequencing are decoupled by a
// two-entry queue, so new items are taken while a phase waits in the output
// register. Configuration registers (bus mode, phase hold ticks) are written
// through csr_ and should change only while the block is idle.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic [7:0]                        req_byte_value,
   input  logic [1:0]                        req_row,
   input  logic [5:0]                        req_column,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_rs_pin,
   output logic                              rsp_rw_pin,
   output logic                              rsp_enable_pin,
   output logic [7:0]                        rsp_data_port,
   output logic [15:0]                       rsp_hold_time,
   output logic                              rsp_last_phase,
   input  logic                              csr_we,
   input  logic [lcdws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                       csr_wdata
);
   import lcdws_pkg::*;

   // Configuration registers.
   logic [1:0]  bus_mode_ff, bus_mode_in;
   logic [15:0] phase_hold_ff, phase_hold_in;

   always_comb begin
      bus_mode_in   = bus_mode_ff;
      phase_hold_in = phase_hold_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BUS_MODE:   bus_mode_in   = csr_wdata[1:0];
            CSR_PHASE_HOLD: phase_hold_in = csr_wdata;
            default:        bus_mode_in   = bus_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_mode_ff   <= BUS_MODE_RESET;
         phase_hold_ff <= PHASE_HOLD_RESET;
      end else begin
         bus_mode_ff   <= bus_mode_in;
         phase_hold_ff <= phase_hold_in;
      end
   end

   // Front: classify the item and push it into the queue.
   logic            q_full, q_push, q_pop, q_valid;
   entry_type       q_entry, q_head;
   back_status_type back_status;

   lcdws_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   lcdws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   // Back: expand each byte into pin phases.
   lcdws_back u_back (
      .clock          (clock),
      .reset          (reset),
      .bus_mode       (bus_mode_ff),
      .phase_hold     (phase_hold_ff),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rs_pin     (rsp_rs_pin),
      .rsp_rw_pin     (rsp_rw_pin),
      .rsp_enable_pin (rsp_enable_pin),
      .rsp_data_port  (rsp_data_port),
      .rsp_hold_time  (rsp_hold_time),
      .rsp_last_phase (rsp_last_phase),
      .status         (back_status)
   );

   // The sequencer never runs past the last phase of a four-bit transfer.
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> (back_status.phase <= PHASE_LAST_NIBBLE))
      else $error("phase counter past the last phase");

   // A request always ends with the enable strobe low.
   a_last_strobe_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_phase) |-> !rsp_enable_pin)
      else $error("last phase with enable high");

   // Register select does not change between phases of one request.
   a_rs_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_phase) |=>
         (!rsp_valid || (rsp_rs_pin == $past(rsp_rs_pin))))
      else $error("register select changed within a request");

endmodule

// ===== verif/tb_char_lcd_write_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_write_sequencer: self-checking testbench of the LCD write sequencer
// Drives command, data and cursor requests under several bus modes and hold
// settings and checks every pin phase item against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_char_lcd_write_sequencer;
   import lcdws_pkg::*;

   localparam int         CLOCK_PERIOD  = 4;
   localparam int         RESET_CYCLES  = 8;
   localparam int         MAX_GAP       = 19;
   localparam int         RANDOM_PHASES = 10;
   localparam int         PHASE_ITEMS   = 22;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         REPORT_LIMIT  = 10;
   localparam int         PLAN_ROWS     = 18;
   localparam longint     CYCLE_LIMIT   = 300000;
   // The fourth bus mode code is unused and must act as the eight-bit bus.
   localparam logic [1:0] MODE_SPARE    = 2'd3;
   // DDRAM address of column 0 on each display row.
   localparam logic [7:0] ROW_BASE [4]  = '{8'h00, 8'h40, 8'h10, 8'h50};

   // One pin phase as it appears on the result channel.
   typedef struct packed {
      logic        rs;
      logic        rw;
      logic        en;
      logic [7:0]  port;
      logic [15:0] hold;
      logic        last;
   } pin_phase_t;

   // One row of the directed plan. When pinned is set, final_port is the
   // hand-computed port value of the last phase and replaces the prediction.
   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] hold;
      opcode_type  op;
      logic [7:0]  value;
      logic [1:0]  row;
      logic [5:0]  column;
      logic        pinned;
      logic [7:0]  final_port;
   } plan_row_t;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_opcode;
   logic [7:0]           req_byte_value;
   logic [1:0]           req_row;
   logic [5:0]           req_column;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_rs_pin;
   logic                 rsp_rw_pin;
   logic                 rsp_enable_pin;
   logic [7:0]           rsp_data_port;
   logic [15:0]          rsp_hold_time;
   logic                 rsp_last_phase;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   // Shadow copy of the block's configuration and port latch.
   logic [1:0]   mode_shadow;
   logic [15:0]  hold_shadow;
   logic [7:0]   latch_shadow;

   // Pin phases predicted but not yet seen on the result channel, oldest first.
   pin_phase_t   pending_phases [$];

   int unsigned  fail_count   = 0;
   int unsigned  report_count = 0;
   longint       cycle_count  = 0;
   // When set, both sides run without idle cycles for a stretch.
   bit           quiet_run    = 1'b0;

   char_lcd_write_sequencer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rs_pin     (rsp_rs_pin),
      .rsp_rw_pin     (rsp_rw_pin),
      .rsp_enable_pin (rsp_enable_pin),
      .rsp_data_port  (rsp_data_port),
      .rsp_hold_time  (rsp_hold_time),
      .rsp_last_phase (rsp_last_phase),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Idle cycles before the next item on either side.
   function automatic int unsigned draw_gap();
      return quiet_run ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void add_phase(logic rs, logic en, logic [7:0] port,
                                     logic [15:0] hold, logic last);
      pin_phase_t ph;
      ph = '{rs, 1'b0, en, port, hold, last};
      pending_phases.push_back(ph);
   endfunction

   // Expands one accepted request into its pin phases and updates the latch.
   function automatic void expand_request(opcode_type op, logic [7:0] value,
                                          logic [1:0] row, logic [5:0] column,
                                          logic pinned, logic [7:0] final_port);
      logic [7:0]  cmd;
      logic [7:0]  port;
      logic [15:0] hold;
      logic [5:0]  col;
      logic        rs;
      // The unused opcode is swallowed without any pin activity.
      if (op == OP_NONE) return;
      // A zero hold setting still holds each phase for one tick.
      hold = (hold_shadow == 16'd0) ? 16'd1 : hold_shadow;
      if (op == OP_CURSOR) begin
         // Columns past the end of the line stick at the last column.
         col = (column > MAX_COLUMN) ? MAX_COLUMN : column;
         cmd = (8'(col) + ROW_BASE[row]) | SET_DDRAM;
         rs  = 1'b0;
      end else begin
         cmd = value;
         rs  = (op == OP_DATA);
      end
      // Setup phases show whatever the port held before.
      port = latch_shadow;
      add_phase(rs, 1'b0, port, hold, 1'b0);
      add_phase(rs, 1'b1, port, hold, 1'b0);
      if (mode_shadow == MODE_UPPER || mode_shadow == MODE_LOWER) begin
         // High nibble first; the idle half of the port keeps its old bits.
         if (mode_shadow == MODE_UPPER) port = {cmd[7:4], port[3:0]};
         else port = {port[7:4], cmd[7:4]};
         add_phase(rs, 1'b1, port, hold, 1'b0);
         add_phase(rs, 1'b0, port, hold, 1'b0);
         add_phase(rs, 1'b1, port, hold, 1'b0);
         if (mode_shadow == MODE_UPPER) port = {cmd[3:0], port[3:0]};
         else port = {port[7:4], cmd[3:0]};
         add_phase(rs, 1'b1, port, hold, 1'b0);
      end else begin
         // Eight-bit bus, including the spare mode code.
         port = cmd;
         add_phase(rs, 1'b1, port, hold, 1'b0);
      end
      add_phase(rs, 1'b0, pinned ? final_port : port, hold, 1'b1);
      latch_shadow = port;
   endfunction

   task automatic log_failure(string what, pin_phase_t want, pin_phase_t got);
      fail_count++;
      if (report_count < REPORT_LIMIT) begin
         report_count++;
         $display("%0t %s: expected rs=%0d rw=%0d en=%0d port=%02h hold=%0d last=%0d",
                  $realtime, what, want.rs, want.rw, want.en, want.port, want.hold,
                  want.last);
         $display("%0t %s: actual   rs=%0d rw=%0d en=%0d port=%02h hold=%0d last=%0d",
                  $realtime, what, got.rs, got.rw, got.en, got.port, got.hold, got.last);
      end
   endtask

   // Presents one request after a random gap and waits until it is taken.
   // Valid stays high into the next item when that item has no gap, so it is
   // only lowered here when a gap follows.
   task automatic send_request(opcode_type op, logic [7:0] value, logic [1:0] row,
                               logic [5:0] column, logic pinned, logic [7:0] final_port);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_byte_value <= value;
      req_row        <= row;
      req_column     <= column;
      do @(posedge clock); while (!req_ready);
      // The item was taken at this edge; its phases cannot appear before the
      // next edge, so predicting here keeps the queue ahead of the checker.
      expand_request(op, value, row, column, pinned, final_port);
   endtask

   // Drops valid and waits until every predicted phase has come out, then waits
   // out the settle period before returning.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_phases.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers while the block is idle.
   task automatic apply_setting(logic [1:0] mode, logic [15:0] hold);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_BUS_MODE;
      csr_wdata <= {14'd0, mode};
      @(posedge clock);
      mode_shadow = mode;
      csr_index <= CSR_PHASE_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      hold_shadow = hold;
      csr_we <= 1'b0;
   endtask

   // Result side: each phase item waits a random number of cycles before
   // ready goes high; ready is only lowered when the next wait is nonzero.
   initial begin : rsp_pacing
      int unsigned stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      stall = draw_gap();
      forever begin
         if (stall == 0) begin
            rsp_ready <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            stall = draw_gap();
            if (stall != 0) rsp_ready <= 1'b0;
         end else begin
            repeat (stall) @(posedge clock);
            stall = 0;
         end
      end
   end

   // Checker: every accepted phase item is compared with the oldest prediction.
   always @(posedge clock) begin : phase_check
      pin_phase_t got;
      pin_phase_t want;
      got = '{rsp_rs_pin, rsp_rw_pin, rsp_enable_pin, rsp_data_port, rsp_hold_time,
              rsp_last_phase};
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_phases.size() == 0) begin
            want = '0;
            log_failure("phase item with nothing pending", want, got);
         end else begin
            want = pending_phases.pop_front();
            if (got !== want) log_failure("phase item mismatch", want, got);
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_char_lcd_write_sequencer NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_t   plan [PLAN_ROWS];
      int unsigned sent;
      int unsigned pick;
      logic [1:0]  mode;
      logic [15:0] hold;
      opcode_type  op;

      // Directed plan. Final port values follow the latch from row to row,
      // starting from the cleared latch and the reset setting (upper nibble,
      // 600 ticks).
      plan[0]  = '{MODE_UPPER, 16'd600,   OP_COMMAND, 8'h00, 2'd0, 6'd0,  1'b1, 8'h00};
      plan[1]  = '{MODE_UPPER, 16'd600,   OP_COMMAND, 8'hFF, 2'd0, 6'd0,  1'b1, 8'hF0};
      plan[2]  = '{MODE_UPPER, 16'd600,   OP_DATA,    8'hA5, 2'd3, 6'd63, 1'b1, 8'h50};
      plan[3]  = '{MODE_UPPER, 16'd600,   OP_CURSOR,  8'hFF, 2'd0, 6'd0,  1'b1, 8'h00};
      plan[4]  = '{MODE_UPPER, 16'd600,   OP_CURSOR,  8'h00, 2'd3, 6'd39, 1'b1, 8'h70};
      // Column past the end of the line saturates.
      plan[5]  = '{MODE_UPPER, 16'd600,   OP_CURSOR,  8'h00, 2'd1, 6'd63, 1'b1, 8'h70};
      // Unused opcode: nothing comes out and the latch is untouched.
      plan[6]  = '{MODE_UPPER, 16'd600,   OP_NONE,    8'hFF, 2'd3, 6'd63, 1'b0, 8'h00};
      plan[7]  = '{MODE_LOWER, 16'd1,     OP_DATA,    8'h3C, 2'd0, 6'd0,  1'b1, 8'h7C};
      plan[8]  = '{MODE_LOWER, 16'd1,     OP_CURSOR,  8'h00, 2'd2, 6'd40, 1'b1, 8'h77};
      plan[9]  = '{MODE_LOWER, 16'd1,     OP_COMMAND, 8'h00, 2'd0, 6'd0,  1'b1, 8'h70};
      plan[10] = '{MODE_8BIT,  16'hFFFF,  OP_COMMAND, 8'h5A, 2'd0, 6'd0,  1'b1, 8'h5A};
      plan[11] = '{MODE_8BIT,  16'hFFFF,  OP_DATA,    8'hFF, 2'd0, 6'd0,  1'b1, 8'hFF};
      plan[12] = '{MODE_8BIT,  16'hFFFF,  OP_DATA,    8'h00, 2'd0, 6'd0,  1'b1, 8'h00};
      // Spare bus mode acts as eight-bit, and a zero hold becomes one tick.
      plan[13] = '{MODE_SPARE, 16'd0,     OP_CURSOR,  8'h00, 2'd3, 6'd63, 1'b1, 8'hF7};
      plan[14] = '{MODE_SPARE, 16'd0,     OP_DATA,    8'h81, 2'd0, 6'd0,  1'b1, 8'h81};
      plan[15] = '{MODE_UPPER, 16'd2,     OP_DATA,    8'h12, 2'd0, 6'd0,  1'b1, 8'h21};
      plan[16] = '{MODE_LOWER, 16'hFFFF,  OP_NONE,    8'h00, 2'd0, 6'd0,  1'b0, 8'h00};
      plan[17] = '{MODE_LOWER, 16'hFFFF,  OP_COMMAND, 8'hC3, 2'd0, 6'd0,  1'b1, 8'h23};

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= OP_COMMAND;
      req_byte_value <= 8'h00;
      req_row        <= 2'd0;
      req_column     <= 6'd0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_BUS_MODE;
      csr_wdata      <= 16'd0;
      mode_shadow    = BUS_MODE_RESET;
      hold_shadow    = PHASE_HOLD_RESET;
      latch_shadow   = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].mode != mode_shadow || plan[i].hold != hold_shadow)
            apply_setting(plan[i].mode, plan[i].hold);
         send_request(plan[i].op, plan[i].value, plan[i].row, plan[i].column,
                      plan[i].pinned, plan[i].final_port);
      end

      // Random part: a new setting per stretch, the extremes first.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin mode = MODE_UPPER; hold = 16'd1;    end
            1: begin mode = MODE_LOWER; hold = 16'hFFFF; end
            2: begin mode = MODE_8BIT;  hold = 16'd1;    end
            3: begin mode = MODE_SPARE; hold = 16'd0;    end
            default: begin
               mode = 2'($urandom_range(0, 3));
               pick = $urandom_range(0, 5);
               if (pick == 0) hold = 16'd1;
               else if (pick == 1) hold = 16'hFFFF;
               else hold = 16'($urandom);
            end
         endcase
         apply_setting(mode, hold);
         quiet_run = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 15);
            op = (pick == 0) ? OP_NONE : opcode_type'(pick % 3);
            send_request(op, 8'($urandom), 2'($urandom_range(0, 3)),
                         ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                                     : 6'($urandom_range(0, 39)),
                         1'b0, 8'h00);
            // Ignored requests do not count toward the stretch.
            if (op != OP_NONE) sent++;
         end
      end

      quiet_run = 1'b0;
      settle();
      if (pending_phases.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("tb_char_lcd_write_sequencer OK");
      end else begin
         $display("tb_char_lcd_write_sequencer NOT OK");
      end
      $finish;
   end

endmodule
